@@ design/aesbc_pkg.sv @@
// Shared types, constants and byte-level functions of the AES block cipher core.
// Holds the S-box tables, MixColumns helpers and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aesbc_pkg;

   localparam int STORE_DEPTH = 60;

   localparam logic [2:0] REG_KEY_SIZE = 3'd0;
   localparam logic [2:0] REG_KEY_0    = 3'd1;
   localparam logic [2:0] REG_KEY_1    = 3'd2;
   localparam logic [2:0] REG_KEY_2    = 3'd3;
   localparam logic [2:0] REG_KEY_3    = 3'd4;

   typedef logic [3:0][63:0] key_regs_type;

   typedef struct packed {
      logic       start;
      logic       op;
      logic [1:0] key_size;
   } cipher_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } cipher_sts_type;

   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_BITS[{~x, 3'b111} -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_BITS[{~x, 3'b111} -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0]  a [4];
      logic [7:0]  d [4];
      logic [31:0] r;
      for (int i = 0; i < 4; i++) begin
         a[i] = c[31 - 8 * i -: 8];
         d[i] = xtime(a[i]);
      end
      for (int i = 0; i < 4; i++) begin
         r[31 - 8 * i -: 8] = d[i] ^ d[(i + 1) & 3] ^ a[(i + 1) & 3] ^ a[(i + 2) & 3]
                              ^ a[(i + 3) & 3];
      end
      return r;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0]  a [4];
      logic [7:0]  m2 [4];
      logic [7:0]  m4 [4];
      logic [7:0]  m8 [4];
      logic [7:0]  e9 [4];
      logic [7:0]  e11 [4];
      logic [7:0]  e13 [4];
      logic [7:0]  e14 [4];
      logic [31:0] r;
      for (int i = 0; i < 4; i++) begin
         a[i]   = c[31 - 8 * i -: 8];
         m2[i]  = xtime(a[i]);
         m4[i]  = xtime(m2[i]);
         m8[i]  = xtime(m4[i]);
         e9[i]  = m8[i] ^ a[i];
         e11[i] = m8[i] ^ m2[i] ^ a[i];
         e13[i] = m8[i] ^ m4[i] ^ a[i];
         e14[i] = m8[i] ^ m4[i] ^ m2[i];
      end
      for (int i = 0; i < 4; i++) begin
         r[31 - 8 * i -: 8] = e14[i] ^ e11[(i + 1) & 3] ^ e13[(i + 2) & 3] ^ e9[(i + 3) & 3];
      end
      return r;
   endfunction

   // Key size code three behaves as a 256-bit key.
   function automatic logic [3:0] rounds_of(input logic [1:0] ks);
      case (ks)
         2'd0:    return 4'd10;
         2'd1:    return 4'd12;
         default: return 4'd14;
      endcase
   endfunction

   function automatic logic [2:0] key_words_m1(input logic [1:0] ks);
      case (ks)
         2'd0:    return 3'd3;
         2'd1:    return 3'd5;
         default: return 3'd7;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ design/aesbc_if.sv @@
// Valid/ready channel interfaces for the AES block cipher core.
// Depends on nothing; the payload follows the block's request and response items.
`timescale 1ns / 1ps
`default_nettype none

interface aesbc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] block_high;
   logic [63:0] block_low;
   modport source (output valid, op, block_high, block_low, input ready);
   modport sink (input valid, op, block_high, block_low, output ready);
endinterface

interface aesbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink (input valid, result_high, result_low, output ready);
endinterface

`default_nettype wire

@@ design/aes_block_cipher_core.sv @@
// AES-128/192/256 core. A new request is taken only after the round datapath, which
// handles one column and one round-key word per cycle, has passed its previous result
// to the output register. Reset is synchronous: key registers clear, then the schedule
// of the zero 128-bit key is built; after each write to the key size or a key register
// it is rebuilt, one word per cycle, with the request channel held off.
// Uses aesbc_pkg and aesbc_if.
`timescale 1ns / 1ps
`default_nettype none

module aes_block_cipher_core (
   input  wire logic         clock,
   input  wire logic         reset,
   aesbc_req_if.sink         req_chan,
   aesbc_rsp_if.source       rsp_chan,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [5:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   logic [1:0]                key_size_ff;
   aesbc_pkg::key_regs_type   key_ff;
   logic [2:0]                reg_idx;
   logic [1:0]                key_sel;
   logic                      csr_wr;
   logic                      sched_start;
   logic                      sched_busy;
   logic [5:0]                key_addr;
   logic [31:0]               key_word;
   aesbc_pkg::cipher_cmd_type cmd;
   aesbc_pkg::cipher_sts_type sts;
   logic [127:0]              result;
   logic                      result_ack;
   logic                      rsp_valid_ff;
   logic [127:0]              rsp_data_ff;

   assign csr_pready  = 1'b1;
   assign reg_idx     = csr_paddr[5:3];
   assign key_sel     = 2'(reg_idx - aesbc_pkg::REG_KEY_0);
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sched_start = csr_wr && (reg_idx <= aesbc_pkg::REG_KEY_3);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         key_ff      <= '0;
      end else if (csr_wr) begin
         case (reg_idx) inside
            aesbc_pkg::REG_KEY_SIZE:                       key_size_ff <= csr_pwdata[1:0];
            [aesbc_pkg::REG_KEY_0 : aesbc_pkg::REG_KEY_3]: key_ff[key_sel] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx) inside
         aesbc_pkg::REG_KEY_SIZE:                       csr_prdata = {62'd0, key_size_ff};
         [aesbc_pkg::REG_KEY_0 : aesbc_pkg::REG_KEY_3]: csr_prdata = key_ff[key_sel];
         default:                                       csr_prdata = '0;
      endcase
   end

   aesbc_key_sched u_key_sched (
      .clock    (clock),
      .reset    (reset),
      .start    (sched_start),
      .key_size (key_size_ff),
      .key_regs (key_ff),
      .rd_addr  (key_addr),
      .rd_data  (key_word),
      .busy     (sched_busy)
   );

   assign req_chan.ready = sts.idle && !sched_busy && !csr_wr;
   assign cmd.start      = req_chan.valid && req_chan.ready;
   assign cmd.op         = req_chan.op;
   assign cmd.key_size   = key_size_ff;

   aesbc_round_unit u_round_unit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .block_in   ({req_chan.block_high, req_chan.block_low}),
      .key_addr   (key_addr),
      .key_word   (key_word),
      .sts        (sts),
      .result_ack (result_ack),
      .result     (result)
   );

   // The output register frees the round unit while a response waits downstream.
   assign result_ack = sts.done && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_ack) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_high = rsp_data_ff[127:64];
   assign rsp_chan.result_low  = rsp_data_ff[63:0];

endmodule

`default_nettype wire

@@ design/aesbc_key_sched.sv @@
// Key expansion engine and round-key store of the AES core.
// Builds one schedule word per cycle; uses aesbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_key_sched (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            key_size,
   input  wire aesbc_pkg::key_regs_type key_regs,
   input  wire logic [5:0]            rd_addr,
   output logic [31:0]                rd_data,
   output logic                       busy
);

   logic        busy_ff, busy_in;
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  mod_ff, mod_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [31:0] win_ff [8];
   logic [31:0] word;
   logic [31:0] key_word;
   logic [31:0] temp;
   logic [31:0] far_word;
   logic [2:0]  nk_m1;
   logic [5:0]  last_idx;
   logic [31:0] mem [aesbc_pkg::STORE_DEPTH];
   logic [31:0] rd_q;

   assign nk_m1    = aesbc_pkg::key_words_m1(key_size);
   assign last_idx = {aesbc_pkg::rounds_of(key_size), 2'b11};
   assign key_word = idx_ff[0] ? key_regs[idx_ff[2:1]][31:0] : key_regs[idx_ff[2:1]][63:32];
   assign far_word = win_ff[nk_m1];

   always_comb begin
      rcon_in = rcon_ff;
      temp    = win_ff[0];
      if (mod_ff == 3'd0) begin
         temp    = aesbc_pkg::sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_ff, 24'd0};
      end else if (nk_m1 == 3'd7 && mod_ff == 3'd4) begin
         temp    = aesbc_pkg::sub_word(win_ff[0]);
      end
      if ({3'd0, idx_ff} <= {6'd0, nk_m1}) begin
         word = key_word;
      end else begin
         word = far_word ^ temp;
         if (mod_ff == 3'd0) begin
            rcon_in = aesbc_pkg::xtime(rcon_ff);
         end
      end
      mod_in  = (mod_ff == nk_m1) ? 3'd0 : mod_ff + 3'd1;
      idx_in  = idx_ff + 6'd1;
      busy_in = busy_ff && (idx_ff != last_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         mod_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (start) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         mod_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         mod_ff  <= mod_in;
         rcon_ff <= rcon_in;
      end
   end

   // The last eight schedule words, newest first, feed the recurrence.
   always_ff @(posedge clock) begin
      if (busy_ff && !start && !reset) begin
         win_ff[0] <= word;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start && !reset) begin
         mem[idx_ff] <= word;
      end
      rd_q <= mem[rd_addr];
   end

   assign rd_data = rd_q;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

@@ design/aesbc_round_unit.sv @@
// Column-serial AES round datapath: one 32-bit state column per cycle.
// Reads one round-key word per cycle from the schedule store; uses aesbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_round_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire aesbc_pkg::cipher_cmd_type cmd,
   input  wire logic [127:0]             block_in,
   output logic [5:0]                    key_addr,
   input  wire logic [31:0]              key_word,
   output aesbc_pkg::cipher_sts_type     sts,
   input  wire logic                     result_ack,
   output logic [127:0]                  result
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [5:0]   step_ff;
   logic         op_ff;
   logic [3:0]   nr_ff;
   logic [127:0] st_ff;
   logic [95:0]  acc_ff;
   logic [3:0]   rnd;
   logic [1:0]   col;
   logic         first_rnd;
   logic         last_rnd;
   logic         last_step;
   logic [7:0]   st_b [16];
   logic [31:0]  col_v;
   logic [31:0]  keyed;
   logic [31:0]  col_out;
   logic [5:0]   next_step;

   function automatic logic [5:0] addr_of(input logic [5:0] step, input logic op,
                                          input logic [3:0] nr);
      logic [3:0] kr;
      kr = op ? nr - step[5:2] : step[5:2];
      return {kr, step[1:0]};
   endfunction

   assign rnd       = step_ff[5:2];
   assign col       = step_ff[1:0];
   assign first_rnd = (rnd == 4'd0);
   assign last_rnd  = (rnd == nr_ff);
   assign last_step = (step_ff == {nr_ff, 2'b11});
   assign next_step = step_ff + 6'd1;

   always_comb begin
      if (cmd.start) begin
         key_addr = addr_of(6'd0, cmd.op, aesbc_pkg::rounds_of(cmd.key_size));
      end else if (state_ff == ST_RUN && !last_step) begin
         key_addr = addr_of(next_step, op_ff, nr_ff);
      end else begin
         key_addr = '0;
      end
   end

   // Row r of the new column comes from column col+r (encrypt) or col-r (decrypt); the first round takes column col.
   always_comb begin
      logic [1:0] src;
      logic [7:0] b;
      for (int i = 0; i < 16; i++) begin
         st_b[i] = st_ff[127 - 8 * i -: 8];
      end
      for (int r = 0; r < 4; r++) begin
         if (first_rnd) begin
            src = col;
         end else if (op_ff) begin
            src = col - 2'(r);
         end else begin
            src = col + 2'(r);
         end
         b = st_b[{src, 2'(r)}];
         if (!first_rnd) begin
            b = op_ff ? aesbc_pkg::inv_sbox(b) : aesbc_pkg::sbox(b);
         end
         col_v[31 - 8 * r -: 8] = b;
      end
      keyed = col_v ^ key_word;
      if (first_rnd || last_rnd) begin
         col_out = keyed;
      end else if (op_ff) begin
         col_out = aesbc_pkg::inv_mix_col(keyed);
      end else begin
         col_out = aesbc_pkg::mix_col(col_v) ^ key_word;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.start) state_in = ST_RUN;
         ST_RUN:  if (last_step) state_in = ST_HOLD;
         ST_HOLD: if (result_ack) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd.start) begin
         st_ff   <= block_in;
         step_ff <= '0;
         op_ff   <= cmd.op;
         nr_ff   <= aesbc_pkg::rounds_of(cmd.key_size);
      end else if (state_ff == ST_RUN) begin
         step_ff <= next_step;
         if (col == 2'd3) begin
            st_ff <= {acc_ff, col_out};
         end else begin
            acc_ff <= {acc_ff[63:0], col_out};
         end
      end
   end

   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = (state_ff == ST_HOLD);
   assign result   = st_ff;

endmodule

`default_nettype wire

@@ design/aesbc_checker.sv @@
// Port-level assertions for the AES block cipher core, bound to the top level.
// Depends on aes_block_cipher_core, aesbc_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [127:0] rsp_data,
   input wire logic         csr_write
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("request taken while a transaction is in flight");

   a_rebuild_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_ready)
      else $error("request channel open during schedule rebuild");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("bad state after reset");

endmodule

// Only writes to mapped registers start a schedule rebuild.
bind aes_block_cipher_core aesbc_checker u_aesbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  ({rsp_chan.result_high, rsp_chan.result_low}),
   .csr_write (csr_psel & csr_penable & csr_pwrite & csr_pready
               & (csr_paddr[5:3] <= aesbc_pkg::REG_KEY_3))
);

`default_nettype wire
